// ----- rtl/core/dgsp_pkg.sv -----
// Shared widths, types and constants for the distance gain and placement block.
// Used by the channel interfaces and every module under rtl/core.
`default_nettype none
package dgsp_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = 18;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int V_W     = SUM_W + 16;
  localparam int SQRT_N  = V_W / 2;
  localparam int D_W     = SQRT_N;
  localparam int CFG_W   = 16;
  localparam int DEN_W   = CFG_W + 8;
  localparam int Q_W     = 16;
  localparam int GAIN_W  = 17;
  localparam int PROD_W  = DIFF_W + GAIN_W + 1;
  localparam int LIS_W   = COORD_W + 16;
  localparam int P_W     = ((PROD_W > LIS_W) ? PROD_W : LIS_W) + 1;
  localparam int HI_W    = P_W - 16;
  localparam int HS_W    = HI_W + CFG_W;
  localparam int SQS_W   = HS_W + 1 - 8;
  localparam int POS_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int N_AXES  = 3;

  localparam logic [MAG_W-1:0]    DIFF_CLAMP = MAG_W'(1) << 17;
  localparam logic [GAIN_W-1:0]   GAIN_ONE   = GAIN_W'(1) << 16;
  localparam logic [GAIN_W-1:0]   GAIN_ZERO  = '0;
  localparam logic [SQS_W-1:0]    SAT_POS    = SQS_W'(23'h7FFFFF);
  localparam logic [SQS_W-1:0]    SAT_NEG    = SQS_W'(24'h800000);
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  localparam logic [CFG_W-1:0] RST_MAX_DIST  = 16'd1500;
  localparam logic [CFG_W-1:0] RST_FULL_DIST = 16'd300;
  localparam logic [CFG_W-1:0] RST_OCC       = 16'd19661;
  localparam logic [CFG_W-1:0] RST_CUTOFF    = 16'd655;
  localparam logic [CFG_W-1:0] RST_SCALE     = 16'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DIST  = 3'd0,
    REG_FULL_DIST = 3'd1,
    REG_OCC       = 3'd2,
    REG_CUTOFF    = 3'd3,
    REG_SCALE     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CASE_FULL,
    CASE_ZERO,
    CASE_DIV
  } gain_case_e;

  typedef struct packed {
    logic [CFG_W-1:0] max_dist;
    logic [CFG_W-1:0] full_dist;
    logic [CFG_W-1:0] occ_factor;
    logic [CFG_W-1:0] cutoff;
    logic [CFG_W-1:0] pos_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] lz;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [DIFF_W-1:0]  dz;
    logic                      occ;
  } item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        gain;
    logic signed [POS_W-1:0]  p_first;
    logic signed [POS_W-1:0]  p_vert;
    logic signed [POS_W-1:0]  p_third;
  } res_t;

  function automatic logic [MAG_W-1:0] clamp_mag(logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0]       a;
    logic [MAG_W+DIFF_W-1:0] m;
    a = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    m = (MAG_W+DIFF_W)'(a);
    if (m > (MAG_W+DIFF_W)'(DIFF_CLAMP)) begin
      return DIFF_CLAMP;
    end
    return m[MAG_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dgsp_ifs.sv -----
// Valid/ready channel interfaces: input items, result items and register writes.
// Depends on dgsp_pkg for widths.
`default_nettype none
interface dgsp_in_if;
  import dgsp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] listener_x;
  logic signed [COORD_W-1:0] listener_y;
  logic signed [COORD_W-1:0] listener_z;
  logic signed [COORD_W-1:0] speaker_x;
  logic signed [COORD_W-1:0] speaker_y;
  logic signed [COORD_W-1:0] speaker_z;
  logic                      occluded;
  modport source (output valid, listener_x, listener_y, listener_z, speaker_x, speaker_y,
                  speaker_z, occluded, input ready);
  modport sink (input valid, listener_x, listener_y, listener_z, speaker_x, speaker_y,
                speaker_z, occluded, output ready);
endinterface

interface dgsp_out_if;
  import dgsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [GAIN_W-1:0]        gain;
  logic signed [POS_W-1:0]  placed_first_axis;
  logic signed [POS_W-1:0]  placed_vertical;
  logic signed [POS_W-1:0]  placed_third_axis;
  modport source (output valid, gain, placed_first_axis, placed_vertical, placed_third_axis,
                  input ready);
  modport sink (input valid, gain, placed_first_axis, placed_vertical, placed_third_axis,
                output ready);
endinterface

interface dgsp_cfg_if;
  import dgsp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/distance_gain_and_source_placement.sv -----
// Top level: register file, distance/gain/placement pipelines and output skid stage.
// Depends on dgsp_pkg, dgsp_ifs, dgsp_dist, dgsp_gain and dgsp_place.
//
// Usage:
//   in_i   takes one beat per listener/speaker pair: signed coordinates and occluded.
//   res_o  gives gain (Q1.16) and the placed position in Q.8, axes x, z, y.
//          A beat whose gain is at or below gain_cutoff produces no result beat.
//   cfg_i  writes the five registers by index; ready is always high. Write only
//          while no beat is in flight. Unknown indexes are ignored.
// The path from input beat to result beat has 30 stages for the
// distance (27 of them one square root digit each), 20 for the gain (16 of them
// one quotient bit each) and 5 for the placement scaling.
// Throughput is one beat per cycle while res_o is ready.
// When the receiver stalls, one result is held in a skid register and the
// pipeline freezes; in_i drops ready only while the skid register is full.
// Reset clears all valid bits and loads the register reset values.
`default_nettype none
module distance_gain_and_source_placement (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dgsp_in_if.sink   in_i,
  dgsp_cfg_if.sink  cfg_i,
  dgsp_out_if.source res_o
);
  import dgsp_pkg::*;

  cfg_t  cfg_q;
  logic  en;
  logic  skid_full_q;
  res_t  skid_q;
  item_t in_item;

  logic  dist_vld, gain_vld, pipe_vld;
  item_t dist_itm, gain_itm;
  logic [D_W-1:0]    dist_val;
  logic [GAIN_W-1:0] gain;
  res_t  pipe_res, out_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_dist   <= RST_MAX_DIST;
      cfg_q.full_dist  <= RST_FULL_DIST;
      cfg_q.occ_factor <= RST_OCC;
      cfg_q.cutoff     <= RST_CUTOFF;
      cfg_q.pos_scale  <= RST_SCALE;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        REG_MAX_DIST:  cfg_q.max_dist   <= cfg_i.data;
        REG_FULL_DIST: cfg_q.full_dist  <= cfg_i.data;
        REG_OCC:       cfg_q.occ_factor <= cfg_i.data;
        REG_CUTOFF:    cfg_q.cutoff     <= cfg_i.data;
        REG_SCALE:     cfg_q.pos_scale  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign en         = !skid_full_q;
  assign in_i.ready = en;

  assign in_item.lx  = in_i.listener_x;
  assign in_item.ly  = in_i.listener_y;
  assign in_item.lz  = in_i.listener_z;
  assign in_item.dx  = DIFF_W'(in_i.speaker_x) - DIFF_W'(in_i.listener_x);
  assign in_item.dy  = DIFF_W'(in_i.speaker_y) - DIFF_W'(in_i.listener_y);
  assign in_item.dz  = DIFF_W'(in_i.speaker_z) - DIFF_W'(in_i.listener_z);
  assign in_item.occ = in_i.occluded;

  dgsp_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .item_i  (in_item),
    .valid_o (dist_vld),
    .item_o  (dist_itm),
    .dist_o  (dist_val)
  );

  dgsp_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (dist_vld),
    .item_i  (dist_itm),
    .dist_i  (dist_val),
    .valid_o (gain_vld),
    .item_o  (gain_itm),
    .gain_o  (gain)
  );

  dgsp_place u_place (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (gain_vld),
    .item_i  (gain_itm),
    .gain_i  (gain),
    .valid_o (pipe_vld),
    .res_o   (pipe_res)
  );

  // hold the last-stage beat when the receiver stalls; pipeline freezes behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (res_o.ready) begin
        skid_full_q <= 1'b0;
      end
    end else if (pipe_vld && !res_o.ready) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q && pipe_vld && !res_o.ready) begin
      skid_q <= pipe_res;
    end
  end

  assign out_res                 = skid_full_q ? skid_q : pipe_res;
  assign res_o.valid             = skid_full_q || pipe_vld;
  assign res_o.gain              = out_res.gain;
  assign res_o.placed_first_axis = out_res.p_first;
  assign res_o.placed_vertical   = out_res.p_vert;
  assign res_o.placed_third_axis = out_res.p_third;
endmodule
`default_nettype wire

// ----- rtl/core/dgsp_dist.sv -----
// Distance pipeline: clamped magnitudes, squares, sum, then one square root digit per stage.
// Depends on dgsp_pkg.
`default_nettype none
module dgsp_dist (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  dgsp_pkg::item_t      item_i,
  output logic                 valid_o,
  output dgsp_pkg::item_t      item_o,
  output logic [dgsp_pkg::D_W-1:0] dist_o
);
  import dgsp_pkg::*;

  logic              mag_vld_q, sq_vld_q;
  item_t             mag_itm_q, sq_itm_q;
  logic [MAG_W-1:0]  mag_q [N_AXES];
  logic [SQ_W-1:0]   sq_q  [N_AXES];

  logic              vld_q [SQRT_N+1];
  item_t             itm_q [SQRT_N+1];
  logic [V_W-1:0]    rem_q [SQRT_N+1];
  logic [V_W-1:0]    res_q [SQRT_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_vld_q <= 1'b0;
      sq_vld_q  <= 1'b0;
      vld_q[0]  <= 1'b0;
    end else if (en_i) begin
      mag_vld_q <= valid_i;
      sq_vld_q  <= mag_vld_q;
      vld_q[0]  <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_itm_q <= item_i;
      mag_q[0]  <= clamp_mag(item_i.dx);
      mag_q[1]  <= clamp_mag(item_i.dy);
      mag_q[2]  <= clamp_mag(item_i.dz);
      sq_itm_q  <= mag_itm_q;
      for (int a = 0; a < N_AXES; a++) begin
        sq_q[a] <= SQ_W'(mag_q[a] * mag_q[a]);
      end
      itm_q[0]  <= sq_itm_q;
      rem_q[0]  <= {SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]), 16'b0};
      res_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    localparam logic [V_W-1:0] BIT = V_W'(1) << (V_W - 2 - 2 * k);
    logic [V_W-1:0] trial;
    logic           take;
    assign trial = res_q[k] + BIT;
    assign take  = rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        itm_q[k+1] <= itm_q[k];
        rem_q[k+1] <= take ? rem_q[k] - trial : rem_q[k];
        res_q[k+1] <= take ? (res_q[k] >> 1) + BIT : res_q[k] >> 1;
      end
    end
  end

  assign valid_o = vld_q[SQRT_N];
  assign item_o  = itm_q[SQRT_N];
  assign dist_o  = res_q[SQRT_N][D_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/dgsp_gain.sv -----
// Gain pipeline: range test, one quotient bit per stage, t squared, falloff and occlusion.
// Depends on dgsp_pkg.
`default_nettype none
module dgsp_gain (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  dgsp_pkg::cfg_t       cfg_i,
  input  wire logic            valid_i,
  input  dgsp_pkg::item_t      item_i,
  input  wire logic [dgsp_pkg::D_W-1:0] dist_i,
  output logic                 valid_o,
  output dgsp_pkg::item_t      item_o,
  output logic [dgsp_pkg::GAIN_W-1:0] gain_o
);
  import dgsp_pkg::*;

  logic [D_W-1:0] full8, max8;
  gain_case_e     case_d;

  logic           vld_q  [Q_W+1];
  item_t          itm_q  [Q_W+1];
  gain_case_e     case_q [Q_W+1];
  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [Q_W-1:0] quo_q  [Q_W+1];

  logic           t_vld_q, g_vld_q, o_vld_q;
  item_t          t_itm_q, g_itm_q, o_itm_q;
  gain_case_e     t_case_q;
  logic [Q_W-1:0] tsq_q;
  logic [GAIN_W-1:0] g_q, o_q, g_d;
  logic [GAIN_W+CFG_W-1:0] occ_prod;

  assign full8 = D_W'({cfg_i.full_dist, 8'b0});
  assign max8  = D_W'({cfg_i.max_dist, 8'b0});

  // full-volume test comes first, so reversed limits never reach the divider
  always_comb begin
    if (dist_i <= full8) begin
      case_d = CASE_FULL;
    end else if (dist_i >= max8) begin
      case_d = CASE_ZERO;
    end else begin
      case_d = CASE_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
      t_vld_q  <= 1'b0;
      g_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      t_vld_q  <= vld_q[Q_W];
      g_vld_q  <= t_vld_q;
      o_vld_q  <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      itm_q[0]  <= item_i;
      case_q[0] <= case_d;
      rem_q[0]  <= DEN_W'(dist_i - full8);
      den_q[0]  <= DEN_W'(max8 - full8);
      quo_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [DEN_W:0] r2;
    logic           ge;
    assign r2 = {rem_q[k], 1'b0};
    assign ge = r2 >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        itm_q[k+1]  <= itm_q[k];
        case_q[k+1] <= case_q[k];
        den_q[k+1]  <= den_q[k];
        rem_q[k+1]  <= ge ? DEN_W'(r2 - {1'b0, den_q[k]}) : r2[DEN_W-1:0];
        quo_q[k+1]  <= {quo_q[k][Q_W-2:0], ge};
      end
    end
  end

  always_comb begin
    case (t_case_q)
      CASE_FULL: g_d = GAIN_ONE;
      CASE_ZERO: g_d = GAIN_ZERO;
      CASE_DIV:  g_d = GAIN_ONE - GAIN_W'(tsq_q);
      default:   g_d = GAIN_ZERO;
    endcase
  end

  assign occ_prod = g_q * cfg_i.occ_factor;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_itm_q  <= itm_q[Q_W];
      t_case_q <= case_q[Q_W];
      tsq_q    <= Q_W'((2*Q_W)'(quo_q[Q_W] * quo_q[Q_W]) >> 16);
      g_itm_q  <= t_itm_q;
      g_q      <= g_d;
      o_itm_q  <= g_itm_q;
      o_q      <= g_itm_q.occ ? occ_prod[GAIN_W+15:16] : g_q;
    end
  end

  assign valid_o = o_vld_q;
  assign item_o  = o_itm_q;
  assign gain_o  = o_q;
endmodule
`default_nettype wire

// ----- rtl/core/dgsp_place.sv -----
// Placement pipeline: cutoff drop, delta times gain, scale by position_scale, saturate.
// Lanes run in output order x, z, y. Depends on dgsp_pkg.
`default_nettype none
module dgsp_place (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  dgsp_pkg::cfg_t       cfg_i,
  input  wire logic            valid_i,
  input  dgsp_pkg::item_t      item_i,
  input  wire logic [dgsp_pkg::GAIN_W-1:0] gain_i,
  output logic                 valid_o,
  output dgsp_pkg::res_t       res_o
);
  import dgsp_pkg::*;

  logic signed [COORD_W-1:0] lis   [N_AXES];
  logic signed [DIFF_W-1:0]  delta [N_AXES];

  logic                      s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [GAIN_W-1:0]         s0_g_q, s1_g_q, s2_g_q, s3_g_q, s4_g_q;
  logic signed [COORD_W-1:0] lis_q  [N_AXES];
  logic signed [PROD_W-1:0]  prod_q [N_AXES];
  logic signed [P_W-1:0]     p_q    [N_AXES];
  logic                      neg2_q [N_AXES];
  logic                      neg3_q [N_AXES];
  logic [HI_W-1:0]           hi_q   [N_AXES];
  logic [15:0]               lo_q   [N_AXES];
  logic [HS_W-1:0]           hs_q   [N_AXES];
  logic [15:0]               ls_q   [N_AXES];
  logic signed [POS_W-1:0]   pos_q  [N_AXES];

  assign lis[0]   = item_i.lx;
  assign lis[1]   = item_i.lz;
  assign lis[2]   = item_i.ly;
  assign delta[0] = item_i.dx;
  assign delta[1] = item_i.dz;
  assign delta[2] = item_i.dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      // drop the beat when the gain does not clear the cutoff
      s0_vld_q <= valid_i && (gain_i > GAIN_W'(cfg_i.cutoff));
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  for (genvar a = 0; a < N_AXES; a++) begin : g_lane
    logic [P_W-1:0]      mag;
    logic [2*CFG_W-1:0]  lo_prod;
    logic [SQS_W-1:0]    q;
    logic signed [P_W-1:0] lis_ext;

    assign lis_ext = P_W'(lis_q[a]) <<< 16;
    assign mag     = p_q[a][P_W-1] ? P_W'(-p_q[a]) : P_W'(p_q[a]);
    assign lo_prod = lo_q[a] * cfg_i.pos_scale;
    assign q       = SQS_W'(((HS_W+1)'(hs_q[a]) + (HS_W+1)'(ls_q[a])) >> 8);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lis_q[a]  <= lis[a];
        prod_q[a] <= PROD_W'(delta[a]) * PROD_W'(signed'({1'b0, gain_i}));
        p_q[a]    <= lis_ext + P_W'(prod_q[a]);
        neg2_q[a] <= p_q[a][P_W-1];
        hi_q[a]   <= mag[P_W-1:16];
        lo_q[a]   <= mag[15:0];
        neg3_q[a] <= neg2_q[a];
        hs_q[a]   <= HS_W'(hi_q[a] * cfg_i.pos_scale);
        ls_q[a]   <= lo_prod[2*CFG_W-1:16];
        if (neg3_q[a]) begin
          pos_q[a] <= (q > SAT_NEG) ? POS_MIN : POS_W'(-q);
        end else begin
          pos_q[a] <= (q > SAT_POS) ? POS_MAX : POS_W'(q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_g_q <= gain_i;
      s1_g_q <= s0_g_q;
      s2_g_q <= s1_g_q;
      s3_g_q <= s2_g_q;
      s4_g_q <= s3_g_q;
    end
  end

  assign valid_o       = s4_vld_q;
  assign res_o.gain    = s4_g_q;
  assign res_o.p_first = pos_q[0];
  assign res_o.p_vert  = pos_q[1];
  assign res_o.p_third = pos_q[2];
endmodule
`default_nettype wire
